FILE: rtl/qslerp_pkg.sv
// Shared types and constants for the quaternion slerp pipeline.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qslerp_pkg;

   // Fixed formats of the block
   localparam int COMP_W        = 16;
   localparam int T_W           = 17;
   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STAGES   = 31;
   localparam int DIV_STAGES    = 31;
   localparam int CW            = 34;
   localparam int CTX_DOT_W     = 30;

   localparam logic [T_W-1:0]  T_ONE         = 17'd65536;
   localparam logic [15:0]     THRESHOLD_RST = 16'd66;
   localparam logic [34:0]     ONE_Q30       = 35'h040000000;
   localparam logic [60:0]     ONE_Q60       = 61'h1000000000000000;
   localparam logic [31:0]     K_LIMIT       = 32'h7FFFFFFF;

   // Register map: byte address bit 2 selects the register index
   localparam logic ADDR_THRESHOLD = 1'b0;

   // Arc tangent of 2^-i in Q2.30 radians
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [COMP_W-1:0] a_x;
      logic signed [COMP_W-1:0] a_y;
      logic signed [COMP_W-1:0] a_z;
      logic signed [COMP_W-1:0] a_w;
      logic signed [COMP_W-1:0] b_x;
      logic signed [COMP_W-1:0] b_y;
      logic signed [COMP_W-1:0] b_z;
      logic signed [COMP_W-1:0] b_w;
      logic        [T_W-1:0]    weight;
   } req_word_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] r_x;
      logic signed [COMP_W-1:0] r_y;
      logic signed [COMP_W-1:0] r_z;
      logic signed [COMP_W-1:0] r_w;
      logic                     used_linear;
   } rsp_word_type;

   // Per-item context carried down the pipeline
   typedef struct packed {
      logic [3:0][COMP_W-1:0]   a;
      logic [3:0][COMP_W:0]     b;
      logic [T_W-1:0]           t;
      logic                     sph;
      logic [CTX_DOT_W-1:0]     dot;
   } ctx_type;

endpackage

`default_nettype wire

FILE: rtl/qslerp_front.sv
// Front end: input capture, dot product, short-arc flip and 1 - dot^2.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  qslerp_pkg::req_word_type in_word,
   input  logic [15:0]              threshold,
   output logic                     out_valid,
   output qslerp_pkg::ctx_type      out_ctx,
   output logic [60:0]              out_rem
);
   import qslerp_pkg::*;

   logic [4:0]         v_ff;
   logic [4:0]         v_in;
   ctx_type            ctx0_ff, ctx1_ff, ctx2_ff, ctx3_ff, ctx4_ff;
   ctx_type            ctx0_in, ctx2_in;
   logic signed [31:0] prod_ff [4];
   logic signed [31:0] prod_in [4];
   logic [59:0]        sq_ff, sq_in;
   logic [60:0]        rem_ff, rem_in;
   logic signed [33:0] dot_sum;
   logic [33:0]        dot_abs;
   logic               dot_neg;

   // Capture the word: widen b, clamp t at one
   always_comb begin
      ctx0_in     = '0;
      ctx0_in.a   = {in_word.a_w, in_word.a_z, in_word.a_y, in_word.a_x};
      ctx0_in.b   = {{in_word.b_w[15], in_word.b_w}, {in_word.b_z[15], in_word.b_z},
                     {in_word.b_y[15], in_word.b_y}, {in_word.b_x[15], in_word.b_x}};
      ctx0_in.t   = (in_word.weight > T_ONE) ? T_ONE : in_word.weight;
   end

   // Four products in Q2.30
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         prod_in[j] = $signed(ctx0_ff.a[j]) * $signed(ctx0_ff.b[j][15:0]);
      end
   end

   // Sum, fold onto the short arc, pick the path
   always_comb begin
      dot_sum = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      dot_neg = dot_sum[33];
      dot_abs = dot_neg ? 34'(-dot_sum) : 34'(dot_sum);
      ctx2_in = ctx1_ff;
      for (int j = 0; j < 4; j++) begin
         ctx2_in.b[j] = dot_neg ? 17'(17'd0 - ctx1_ff.b[j]) : ctx1_ff.b[j];
      end
      ctx2_in.sph = (({1'b0, dot_abs} + 35'({threshold, 14'd0})) < ONE_Q30);
      ctx2_in.dot = dot_abs[CTX_DOT_W-1:0];
   end

   assign sq_in  = 60'(ctx2_ff.dot) * 60'(ctx2_ff.dot);
   assign rem_in = ONE_Q60 - 61'(sq_ff);
   assign v_in   = {v_ff[3:0], in_valid};

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      ctx0_ff <= ctx0_in;
      ctx1_ff <= ctx0_ff;
      prod_ff <= prod_in;
      ctx2_ff <= ctx2_in;
      ctx3_ff <= ctx2_ff;
      sq_ff   <= sq_in;
      ctx4_ff <= ctx3_ff;
      rem_ff  <= rem_in;
   end

   assign out_valid = v_ff[4];
   assign out_ctx   = ctx4_ff;
   assign out_rem   = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/qslerp_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  qslerp_pkg::ctx_type in_ctx,
   input  logic [60:0]         in_rem,
   output logic                out_valid,
   output qslerp_pkg::ctx_type out_ctx,
   output logic [30:0]         out_root
);
   import qslerp_pkg::*;

   logic        v_ff   [0:SQRT_STAGES];
   ctx_type     ctx_ff [0:SQRT_STAGES];
   logic [61:0] n_ff   [0:SQRT_STAGES];
   logic [61:0] r_ff   [0:SQRT_STAGES];

   // Load the radicand
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= in_ctx;
      n_ff[0]   <= 62'(in_rem);
      r_ff[0]   <= '0;
   end

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
      logic [61:0] trial;
      logic        take;
      logic [61:0] n_in, r_in;

      // Try the next root bit
      assign trial = r_ff[i] + BIT;
      assign take  = n_ff[i] >= trial;
      assign n_in  = take ? n_ff[i] - trial : n_ff[i];
      assign r_in  = take ? (r_ff[i] >> 1) + BIT : r_ff[i] >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         ctx_ff[i+1] <= ctx_ff[i];
         n_ff[i+1]   <= n_in;
         r_ff[i+1]   <= r_in;
      end
   end

   assign out_valid = v_ff[SQRT_STAGES];
   assign out_ctx   = ctx_ff[SQRT_STAGES];
   assign out_root  = r_ff[SQRT_STAGES][30:0];

endmodule

`default_nettype wire

FILE: rtl/qslerp_cordic.sv
// CORDIC angle of (dot, root), the two scaled angles, and three sine rotations.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  qslerp_pkg::ctx_type           in_ctx,
   input  logic [30:0]                   in_root,
   output logic                          out_valid,
   output qslerp_pkg::ctx_type           out_ctx,
   output logic [2:0][qslerp_pkg::CW-1:0] out_sine
);
   import qslerp_pkg::*;

   logic               vv_ff   [0:CORDIC_STAGES];
   ctx_type            vctx_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0] vx_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0] vy_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0] vz_ff [0:CORDIC_STAGES];

   logic               av_ff;
   ctx_type            actx_ff;
   logic signed [CW-1:0] ang_ff [3];
   logic signed [CW-1:0] ang_in [3];
   logic signed [51:0] mul0, mul1;
   logic signed [CW-1:0] theta;

   logic               rv_ff   [0:CORDIC_STAGES];
   ctx_type            rctx_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0] rx_ff [0:CORDIC_STAGES][3];
   logic signed [CW-1:0] ry_ff [0:CORDIC_STAGES][3];
   logic signed [CW-1:0] rz_ff [0:CORDIC_STAGES][3];

   // Load the vector
   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff[0] <= 1'b0;
      end else begin
         vv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      vctx_ff[0] <= in_ctx;
      vx_ff[0]   <= CW'(in_ctx.dot);
      vy_ff[0]   <= CW'(in_root);
      vz_ff[0]   <= '0;
   end

   // Vectoring: drive y toward zero, accumulate the angle
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      logic signed [CW-1:0] x_in, y_in, z_in;
      always_comb begin
         if (!vy_ff[i][CW-1]) begin
            x_in = vx_ff[i] + (vy_ff[i] >>> i);
            y_in = vy_ff[i] - (vx_ff[i] >>> i);
            z_in = vz_ff[i] + CW'(ATAN_TABLE[i]);
         end else begin
            x_in = vx_ff[i] - (vy_ff[i] >>> i);
            y_in = vy_ff[i] + (vx_ff[i] >>> i);
            z_in = vz_ff[i] - CW'(ATAN_TABLE[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[i+1] <= 1'b0;
         end else begin
            vv_ff[i+1] <= vv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         vctx_ff[i+1] <= vctx_ff[i];
         vx_ff[i+1]   <= x_in;
         vy_ff[i+1]   <= y_in;
         vz_ff[i+1]   <= z_in;
      end
   end

   // Scale theta by 1 - t and by t
   always_comb begin
      theta     = vz_ff[CORDIC_STAGES];
      mul0      = $signed({1'b0, 17'(T_ONE - vctx_ff[CORDIC_STAGES].t)}) * theta;
      mul1      = $signed({1'b0, vctx_ff[CORDIC_STAGES].t}) * theta;
      ang_in[0] = theta;
      ang_in[1] = mul0[49:16];
      ang_in[2] = mul1[49:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else begin
         av_ff <= vv_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      actx_ff <= vctx_ff[CORDIC_STAGES];
      ang_ff  <= ang_in;
   end

   // Load the three rotations
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else begin
         rv_ff[0] <= av_ff;
      end
   end

   always_ff @(posedge clock) begin
      rctx_ff[0] <= actx_ff;
      for (int l = 0; l < 3; l++) begin
         rx_ff[0][l] <= CW'(ONE_Q30);
         ry_ff[0][l] <= '0;
         rz_ff[0][l] <= ang_ff[l];
      end
   end

   // Rotation: drive the residual angle toward zero
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [CW-1:0] x_in [3];
      logic signed [CW-1:0] y_in [3];
      logic signed [CW-1:0] z_in [3];
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (!rz_ff[i][l][CW-1]) begin
               x_in[l] = rx_ff[i][l] - (ry_ff[i][l] >>> i);
               y_in[l] = ry_ff[i][l] + (rx_ff[i][l] >>> i);
               z_in[l] = rz_ff[i][l] - CW'(ATAN_TABLE[i]);
            end else begin
               x_in[l] = rx_ff[i][l] + (ry_ff[i][l] >>> i);
               y_in[l] = ry_ff[i][l] - (rx_ff[i][l] >>> i);
               z_in[l] = rz_ff[i][l] + CW'(ATAN_TABLE[i]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[i+1] <= 1'b0;
         end else begin
            rv_ff[i+1] <= rv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         rctx_ff[i+1] <= rctx_ff[i];
         rx_ff[i+1]   <= x_in;
         ry_ff[i+1]   <= y_in;
         rz_ff[i+1]   <= z_in;
      end
   end

   assign out_valid   = rv_ff[CORDIC_STAGES];
   assign out_ctx     = rctx_ff[CORDIC_STAGES];
   assign out_sine[0] = ry_ff[CORDIC_STAGES][0];
   assign out_sine[1] = ry_ff[CORDIC_STAGES][1];
   assign out_sine[2] = ry_ff[CORDIC_STAGES][2];

endmodule

`default_nettype wire

FILE: rtl/qslerp_div.sv
// Two-lane restoring divider forming the spherical weights sin(x)*2^30/sin(theta).
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  qslerp_pkg::ctx_type            in_ctx,
   input  logic [2:0][qslerp_pkg::CW-1:0] in_sine,
   output logic                           out_valid,
   output qslerp_pkg::ctx_type            out_ctx,
   output logic [1:0][31:0]               out_k
);
   import qslerp_pkg::*;

   logic        v_ff   [0:DIV_STAGES];
   ctx_type     ctx_ff [0:DIV_STAGES];
   logic [32:0] rem_ff [0:DIV_STAGES][2];
   logic [30:0] q_ff   [0:DIV_STAGES][2];
   logic [31:0] d_ff   [0:DIV_STAGES];
   logic [1:0]  neg_ff [0:DIV_STAGES];
   logic [1:0]  ovf_ff [0:DIV_STAGES];
   logic [1:0]  lsb_ff;

   logic signed [CW-1:0] st;
   logic [CW-1:0]        s_abs [2];
   logic [1:0]           neg_in, ovf_in;
   ctx_type              ctx_in;

   logic                 kv_ff;
   ctx_type              kctx_ff;
   logic [1:0][31:0]     k_ff, k_in;

   // Split sign and magnitude, flag quotients past the weight limit
   always_comb begin
      st     = $signed(in_sine[0]);
      ctx_in = in_ctx;
      ctx_in.sph = in_ctx.sph && (st > 0);
      for (int l = 0; l < 2; l++) begin
         neg_in[l] = in_sine[l+1][CW-1];
         s_abs[l]  = neg_in[l] ? CW'(-$signed(in_sine[l+1])) : in_sine[l+1];
         ovf_in[l] = {1'b0, s_abs[l]} >= {st, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= ctx_in;
      d_ff[0]   <= st[31:0];
      neg_ff[0] <= neg_in;
      ovf_ff[0] <= ovf_in;
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l] <= s_abs[l][CW-1:1];
         q_ff[0][l]   <= '0;
         lsb_ff[l]    <= s_abs[l][0];
      end
   end

   // One quotient bit per stage; only the first step brings in a dividend bit
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
      logic [33:0] shifted [2];
      logic [1:0]  ge;
      logic [32:0] rem_in [2];
      logic [30:0] q_in [2];
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            shifted[l] = {rem_ff[i][l], (i == 0) ? lsb_ff[l] : 1'b0};
            ge[l]      = shifted[l] >= {2'b00, d_ff[i]};
            rem_in[l]  = ge[l] ? 33'(shifted[l] - {2'b00, d_ff[i]}) : shifted[l][32:0];
            q_in[l]    = {q_ff[i][l][29:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         ctx_ff[i+1] <= ctx_ff[i];
         d_ff[i+1]   <= d_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         ovf_ff[i+1] <= ovf_ff[i];
         rem_ff[i+1] <= rem_in;
         q_ff[i+1]   <= q_in;
      end
   end

   // Clamp and restore the sign
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         k_in[l] = ovf_ff[DIV_STAGES][l] ? K_LIMIT : {1'b0, q_ff[DIV_STAGES][l]};
         if (neg_ff[DIV_STAGES][l]) begin
            k_in[l] = 32'(32'd0 - k_in[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_ff <= 1'b0;
      end else begin
         kv_ff <= v_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      kctx_ff <= ctx_ff[DIV_STAGES];
      k_ff    <= k_in;
   end

   assign out_valid = kv_ff;
   assign out_ctx   = kctx_ff;
   assign out_k     = k_ff;

endmodule

`default_nettype wire

FILE: rtl/qslerp_blend.sv
// Weight selection, weighted sum of both quaternions, rounding and saturation.
// Depends on qslerp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qslerp_blend (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  qslerp_pkg::ctx_type      in_ctx,
   input  logic [1:0][31:0]         in_k,
   output logic                     out_valid,
   output qslerp_pkg::rsp_word_type out_word
);
   import qslerp_pkg::*;

   logic             sv_ff, pv_ff, ov_ff;
   ctx_type          sctx_ff;
   logic [1:0][31:0] k_ff, k_in;
   logic signed [47:0] pa_ff [4];
   logic signed [47:0] pa_in [4];
   logic signed [48:0] pb_ff [4];
   logic signed [48:0] pb_in [4];
   logic             lin_ff;
   rsp_word_type     word_ff, word_in;
   logic signed [49:0] acc [4];
   logic signed [19:0] rnd [4];
   logic signed [15:0] sat [4];

   // Pick spherical or linear weights
   always_comb begin
      if (in_ctx.sph) begin
         k_in = in_k;
      end else begin
         k_in[0] = {1'b0, 17'(T_ONE - in_ctx.t), 14'd0};
         k_in[1] = {1'b0, in_ctx.t, 14'd0};
      end
   end

   // Eight products
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         pa_in[j] = $signed(sctx_ff.a[j]) * $signed(k_ff[0]);
         pb_in[j] = $signed(sctx_ff.b[j]) * $signed(k_ff[1]);
      end
   end

   // Sum, round half up, saturate to Q1.15
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc[j] = 50'(pa_ff[j]) + 50'(pb_ff[j]) + 50'sh20000000;
         rnd[j] = acc[j][49:30];
         if (rnd[j] > 20'sd32767) begin
            sat[j] = 16'sh7FFF;
         end else if (rnd[j] < -20'sd32768) begin
            sat[j] = 16'sh8000;
         end else begin
            sat[j] = rnd[j][15:0];
         end
      end
      word_in.r_x         = sat[0];
      word_in.r_y         = sat[1];
      word_in.r_z         = sat[2];
      word_in.r_w         = sat[3];
      word_in.used_linear = lin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         sv_ff <= in_valid;
         pv_ff <= sv_ff;
         ov_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      sctx_ff <= in_ctx;
      k_ff    <= k_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      lin_ff  <= !sctx_ff.sph;
      word_ff <= word_in;
   end

   assign out_valid = ov_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

FILE: rtl/quaternion_slerp.sv
// Top level of the fixed-point quaternion slerp unit with its register port.
// Depends on qslerp_pkg and the qslerp_front/sqrt/cordic/div/blend stages.
//
// Usage:
//   Input: drive req_word with two Q1.15 quaternions and a Q1.16 weight, and
//   raise start for one cycle per word. busy is always low, so a word is
//   taken at every edge where start is high, one word per cycle sustained.
//   Output: each result appears on rsp_word for exactly one cycle with
//   rsp_strobe high. Results leave in input order. The receiver cannot
//   stall; the pipeline never holds or drops a word.
//   The chain is five front stages, 32 square-root stages (load and 31
//   steps), 17 CORDIC angle stages (load and 16 steps), one scaling
//   multiply, 17 CORDIC sine stages, 33 divider stages (setup, 31 steps
//   and clamp) and three blend stages.
//   Register port: psel/penable/pwrite/paddr/pwdata/prdata/pready, one
//   register (linear_threshold) at byte address 0; pready is always high.
//   Reset (synchronous, active high) clears all valid bits and loads the
//   threshold with 66; words in flight are discarded.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_slerp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  qslerp_pkg::req_word_type req_word,
   output logic                     rsp_strobe,
   output qslerp_pkg::rsp_word_type rsp_word,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import qslerp_pkg::*;

   localparam int LATENCY = 5 + (SQRT_STAGES + 1) + 2 * (CORDIC_STAGES + 1) + 1
                            + (DIV_STAGES + 2) + 3;

   logic [15:0]      threshold_ff, threshold_in;
   logic             wr_en;

   logic             f_valid, s_valid, c_valid, d_valid;
   ctx_type          f_ctx, s_ctx, c_ctx, d_ctx;
   logic [60:0]      f_rem;
   logic [30:0]      s_root;
   logic [2:0][CW-1:0] c_sine;
   logic [1:0][31:0] d_k;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // Register write and readback
   assign wr_en        = psel && penable && pwrite && pready && (paddr[2] == ADDR_THRESHOLD);
   assign threshold_in = wr_en ? pwdata[15:0] : threshold_ff;
   assign prdata       = (paddr[2] == ADDR_THRESHOLD) ? {16'd0, threshold_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   qslerp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_word   (req_word),
      .threshold (threshold_ff),
      .out_valid (f_valid),
      .out_ctx   (f_ctx),
      .out_rem   (f_rem)
   );

   qslerp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ctx    (f_ctx),
      .in_rem    (f_rem),
      .out_valid (s_valid),
      .out_ctx   (s_ctx),
      .out_root  (s_root)
   );

   qslerp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ctx    (s_ctx),
      .in_root   (s_root),
      .out_valid (c_valid),
      .out_ctx   (c_ctx),
      .out_sine  (c_sine)
   );

   qslerp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_ctx    (c_ctx),
      .in_sine   (c_sine),
      .out_valid (d_valid),
      .out_ctx   (d_ctx),
      .out_k     (d_k)
   );

   qslerp_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ctx    (d_ctx),
      .in_k      (d_k),
      .out_valid (rsp_strobe),
      .out_word  (rsp_word)
   );

   // Every taken word comes out after the fixed latency
   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("taken word did not come out after the pipeline latency");

   // No result without a word taken the fixed latency before
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching input word");

endmodule

`default_nettype wire
